/* sv/systmr_pkg.sv */
// ----------------------------------------------------------------------------
// System timer package
// Shared constants, register offsets, item and result types, and helpers.
// ----------------------------------------------------------------------------
package systmr_pkg;

  // Transfer payload widths.
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 4;
  localparam int DATA_W   = 32;

  // Counter widths.
  localparam int COUNT_W   = 20;
  localparam int PERIOD_W  = 17;
  localparam int FIELD16_W = 16;
  localparam int STATUS_W  = 4;
  localparam int TIMERS    = 3;

  // Watchdog slow-clock prescale.
  localparam int WDT_DIVIDE = 128;
  localparam int WDT_PS_W   = (WDT_DIVIDE > 1) ? $clog2(WDT_DIVIDE) : 1;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd2;

  // Register word offsets.
  localparam logic [INDEX_W-1:0] REG_CONTROL     = 4'd0;
  localparam logic [INDEX_W-1:0] REG_INTERVAL    = 4'd1;
  localparam logic [INDEX_W-1:0] REG_WDT_MODE    = 4'd2;
  localparam logic [INDEX_W-1:0] REG_RTT_MODE    = 4'd3;
  localparam logic [INDEX_W-1:0] REG_STATUS      = 4'd4;
  localparam logic [INDEX_W-1:0] REG_INT_ENABLE  = 4'd5;
  localparam logic [INDEX_W-1:0] REG_INT_DISABLE = 4'd6;
  localparam logic [INDEX_W-1:0] REG_INT_MASK    = 4'd7;
  localparam logic [INDEX_W-1:0] REG_ALARM       = 4'd8;
  localparam logic [INDEX_W-1:0] REG_RTT_COUNT   = 4'd9;

  // Bit positions in the run flags.
  localparam int RUN_PIT = 0;
  localparam int RUN_WDT = 1;
  localparam int RUN_RTT = 2;

  // Bit positions in the status word.
  localparam int ST_PIT   = 0;
  localparam int ST_WDT   = 1;
  localparam int ST_RTINC = 2;
  localparam int ST_ALARM = 3;

  // Watchdog interrupt enable bit in the watchdog mode register.
  localparam int WDT_IRQ_EN = 16;

  // Reset values of the mode registers.
  localparam logic [DATA_W-1:0] WDT_MODE_RESET = 32'h0002_0000;
  localparam logic [DATA_W-1:0] RTT_MODE_RESET = 32'h0000_8000;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  reg_index;
    logic [DATA_W-1:0]   write_data;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq;
  } result_t;

  // A 16-bit period field where zero stands for 65536.
  function automatic logic [PERIOD_W-1:0] period16(input logic [FIELD16_W-1:0] v);
    logic [PERIOD_W-1:0] p;
    p = {1'b0, v};
    if (v == '0) begin
      p = {1'b1, {FIELD16_W{1'b0}}};
    end
    return p;
  endfunction

endpackage

/* sv/systmr_item_if.sv */
// ----------------------------------------------------------------------------
// System timer item channel
// Valid/ready channel carrying one bus access or slow-clock tick.
// ----------------------------------------------------------------------------
interface systmr_item_if;
  import systmr_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [INDEX_W-1:0]  reg_index;
  logic [DATA_W-1:0]   write_data;

  modport source (output valid, output action, output reg_index, output write_data,
                  input ready);
  modport sink (input valid, input action, input reg_index, input write_data,
                output ready);
endinterface

/* sv/systmr_result_if.sv */
// ----------------------------------------------------------------------------
// System timer result channel
// Valid/ready channel carrying read data and the interrupt flag.
// ----------------------------------------------------------------------------
interface systmr_result_if;
  import systmr_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              irq;

  modport source (output valid, output read_data, output irq, input ready);
  modport sink (input valid, input read_data, input irq, output ready);
endinterface

/* sv/systmr_engine.sv */
// ----------------------------------------------------------------------------
// System timer engine
// Timer state registers and the single-pass update for one item.
// ----------------------------------------------------------------------------
module systmr_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  systmr_pkg::item_t item,
  output systmr_pkg::result_t result
);
  import systmr_pkg::*;

  logic [DATA_W-1:0]    interval_mode, interval_mode_next;
  logic [DATA_W-1:0]    watchdog_mode, watchdog_mode_next;
  logic [DATA_W-1:0]    rtt_mode, rtt_mode_next;
  logic [DATA_W-1:0]    int_mask, int_mask_next;
  logic [DATA_W-1:0]    alarm_value, alarm_value_next;
  logic [COUNT_W-1:0]   rtt_count, rtt_count_next;
  logic [STATUS_W-1:0]  status_bits, status_bits_next;
  logic [PERIOD_W-1:0]  interval_down, interval_down_next;
  logic [PERIOD_W-1:0]  watchdog_down, watchdog_down_next;
  logic [WDT_PS_W-1:0]  watchdog_prescale, watchdog_prescale_next;
  logic [FIELD16_W-1:0] rtt_prescale, rtt_prescale_next;
  logic [TIMERS-1:0]    timers_running, timers_running_next;

  logic [PERIOD_W-1:0]  pit_period, wdt_period, rtt_period;
  logic [PERIOD_W-1:0]  pit_dec, wdt_dec, rtt_ps_inc;
  logic [COUNT_W-1:0]   count_inc;
  logic [DATA_W-1:0]    rd;
  logic                 irq;

  assign pit_period = period16(interval_mode[FIELD16_W-1:0]);
  assign wdt_period = period16(watchdog_mode[FIELD16_W-1:0]);
  assign rtt_period = period16(rtt_mode[FIELD16_W-1:0]);
  assign pit_dec    = (interval_down != '0) ? interval_down - 1'b1 : '0;
  assign wdt_dec    = (watchdog_down != '0) ? watchdog_down - 1'b1 : '0;
  assign rtt_ps_inc = {1'b0, rtt_prescale} + 1'b1;
  assign count_inc  = rtt_count + 1'b1;

  always_comb begin
    interval_mode_next     = interval_mode;
    watchdog_mode_next     = watchdog_mode;
    rtt_mode_next          = rtt_mode;
    int_mask_next          = int_mask;
    alarm_value_next       = alarm_value;
    rtt_count_next         = rtt_count;
    status_bits_next       = status_bits;
    interval_down_next     = interval_down;
    watchdog_down_next     = watchdog_down;
    watchdog_prescale_next = watchdog_prescale;
    rtt_prescale_next      = rtt_prescale;
    timers_running_next    = timers_running;
    rd                     = '0;
    irq                    = 1'b0;

    case (item.action)
      ACT_READ: begin
        case (item.reg_index)
          REG_INTERVAL:  rd = interval_mode;
          REG_WDT_MODE:  rd = watchdog_mode;
          REG_RTT_MODE:  rd = rtt_mode;
          REG_STATUS:    rd = {{(DATA_W-STATUS_W){1'b0}}, status_bits};
          REG_INT_MASK:  rd = int_mask;
          REG_ALARM:     rd = alarm_value;
          REG_RTT_COUNT: rd = {{(DATA_W-COUNT_W){1'b0}}, rtt_count};
          default:       rd = '0;
        endcase
      end
      ACT_WRITE: begin
        case (item.reg_index)
          REG_CONTROL: begin
            watchdog_down_next           = wdt_period;
            watchdog_prescale_next       = '0;
            timers_running_next[RUN_WDT] = 1'b1;
          end
          REG_INTERVAL: begin
            interval_mode_next           = item.write_data;
            interval_down_next           = period16(item.write_data[FIELD16_W-1:0]);
            timers_running_next[RUN_PIT] = 1'b1;
          end
          REG_WDT_MODE:    watchdog_mode_next = item.write_data;
          REG_RTT_MODE: begin
            rtt_mode_next = item.write_data;
            // A restart of a running RTT also clears its count.
            if (timers_running[RUN_RTT]) begin
              rtt_count_next = '0;
            end
            rtt_prescale_next            = '0;
            timers_running_next[RUN_RTT] = 1'b1;
          end
          REG_INT_ENABLE:  int_mask_next    = int_mask | item.write_data;
          REG_INT_DISABLE: int_mask_next    = int_mask & ~item.write_data;
          REG_ALARM:       alarm_value_next = item.write_data;
          default:         ;
        endcase
      end
      ACT_TICK: begin
        if (timers_running[RUN_PIT]) begin
          if (pit_dec == '0) begin
            status_bits_next[ST_PIT] = 1'b1;
            irq                      = irq | int_mask[ST_PIT];
            interval_down_next       = pit_period;
          end else begin
            interval_down_next = pit_dec;
          end
        end
        if (timers_running[RUN_WDT]) begin
          if (watchdog_prescale == WDT_PS_W'(WDT_DIVIDE - 1)) begin
            watchdog_prescale_next = '0;
            if (wdt_dec == '0) begin
              status_bits_next[ST_WDT] = 1'b1;
              irq = irq | (watchdog_mode[WDT_IRQ_EN] & int_mask[ST_WDT]);
              watchdog_down_next = wdt_period;
            end else begin
              watchdog_down_next = wdt_dec;
            end
          end else begin
            watchdog_prescale_next = watchdog_prescale + 1'b1;
          end
        end
        if (timers_running[RUN_RTT]) begin
          if (rtt_ps_inc >= rtt_period) begin
            rtt_prescale_next          = '0;
            rtt_count_next             = count_inc;
            status_bits_next[ST_RTINC] = 1'b1;
            // An alarm field of zero never matches.
            if ((alarm_value[COUNT_W-1:0] != '0) &&
                (count_inc == alarm_value[COUNT_W-1:0])) begin
              status_bits_next[ST_ALARM] = 1'b1;
              irq = irq | int_mask[ST_ALARM];
            end
          end else begin
            rtt_prescale_next = rtt_ps_inc[FIELD16_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_mode     <= '0;
      watchdog_mode     <= WDT_MODE_RESET;
      rtt_mode          <= RTT_MODE_RESET;
      int_mask          <= '0;
      alarm_value       <= '0;
      rtt_count         <= '0;
      status_bits       <= '0;
      interval_down     <= '0;
      watchdog_down     <= '0;
      watchdog_prescale <= '0;
      rtt_prescale      <= '0;
      timers_running    <= '0;
    end else if (take) begin
      interval_mode     <= interval_mode_next;
      watchdog_mode     <= watchdog_mode_next;
      rtt_mode          <= rtt_mode_next;
      int_mask          <= int_mask_next;
      alarm_value       <= alarm_value_next;
      rtt_count         <= rtt_count_next;
      status_bits       <= status_bits_next;
      interval_down     <= interval_down_next;
      watchdog_down     <= watchdog_down_next;
      watchdog_prescale <= watchdog_prescale_next;
      rtt_prescale      <= rtt_prescale_next;
      timers_running    <= timers_running_next;
    end
  end

  assign result.read_data = rd;
  assign result.irq       = irq;

  // Status bits are sticky: once set, only reset clears them.
  a_status_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ((status_bits & $past(status_bits)) == $past(status_bits)))
    else $error("status bit cleared");

  // The interrupt flag comes only from a slow-clock tick.
  a_irq_on_tick: assert property (@(posedge clk) disable iff (rst)
    result.irq |-> (item.action == ACT_TICK))
    else $error("interrupt raised by a bus access");

  // A running interval timer never holds a zero count.
  a_pit_nonzero: assert property (@(posedge clk) disable iff (rst)
    timers_running[RUN_PIT] |-> (interval_down != '0))
    else $error("interval count at zero while running");

  // The RTT prescaler stays below its period.
  a_rtt_ps_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, rtt_prescale} < rtt_period))
    else $error("rtt prescaler out of range");
endmodule

/* sv/system_timer_pit_wdt_rtt_core.sv */
// ----------------------------------------------------------------------------
// System timer core
// Periodic interval timer, watchdog and 20-bit real-time counter behind a
// valid/ready item channel, one result per item.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Payload                              Transfer when
//   items     in   action, reg_index, write_data        items.valid & items.ready
//   results   out  read_data, irq                       results.valid & results.ready
//
// The block sustains one item per cycle while results.ready stays high.
// An item is held in the input register, passes through the engine's update
// logic, and its result lands in the output register, where it is offered.
// Reset (rst, synchronous) empties both registers and returns every timer
// register to its reset value with all timers stopped.
// While results.ready is low the output register holds; the input register
// still accepts an item if it is empty.
// ----------------------------------------------------------------------------
module system_timer_pit_wdt_rtt_core (
  input logic           clk,
  input logic           rst,
  systmr_item_if.sink     items,
  systmr_result_if.source results
);
  import systmr_pkg::*;

  // Input register.
  logic    in_valid;
  item_t   in_item;

  // Output register.
  logic    out_valid;
  result_t out_result;

  // Combinational result of the item in the input register.
  result_t step_result;

  logic advance;
  logic take;

  // The output register can be loaded when it is empty or being drained.
  assign advance     = !out_valid || results.ready;
  // The input register takes a new item when empty or when its item moves on.
  assign items.ready = !in_valid || advance;
  // The engine commits the held item exactly when its result is captured.
  assign take        = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (items.ready) begin
        in_valid <= items.valid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      in_item.action     <= items.action;
      in_item.reg_index  <= items.reg_index;
      in_item.write_data <= items.write_data;
    end
    if (take) begin
      out_result <= step_result;
    end
  end

  systmr_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .item   (in_item),
    .result (step_result)
  );

  assign results.valid     = out_valid;
  assign results.read_data = out_result.read_data;
  assign results.irq       = out_result.irq;
endmodule
